>>> rtl/core/rtcst_pkg.sv
package rtcst_pkg;

  localparam int COUNTER_BITS_DEF     = 24;
  localparam int TICKS_PER_SECOND_DEF = 32768;
  localparam int SETTLE_TICKS         = 5;
  localparam int MILLIS_PER_SECOND    = 1000;

  // stages from the input register up to the one that feeds the result register
  localparam int PIPE_STAGES = 6;

  localparam logic [2:0] KIND_TICK  = 3'd0;
  localparam logic [2:0] KIND_SET   = 3'd1;
  localparam logic [2:0] KIND_QUERY = 3'd2;
  localparam logic [2:0] KIND_ARM   = 3'd3;
  localparam logic [2:0] KIND_CHECK = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] new_seconds;
    logic [31:0] expiry_stamp;
    logic [31:0] wait_ticks_in;
  } item_t;

  typedef logic [PIPE_STAGES-1:0] stage_en_t;

endpackage

>>> rtl/core/rtc_seconds_timekeeper.sv
// Unix seconds timekeeper driven by tick items from a 32 kHz source.
// Input channel: in_valid/in_stall with kind and its operands; one item is
// transferred at each edge with in_valid high and in_stall low. Kind 0 is a
// tick, 1 loads the seconds (stepping then holds for five ticks), 2 queries,
// 3 converts a wait in microseconds to ticks and an expiry stamp, 4 checks
// an expiry stamp. Codes 5 to 7 behave as a query.
// Output channel: out_valid/out_stall, exactly one result per item, in order.
// The microsecond-to-tick conversion pipeline sets the pipeline depth.
// Throughput is one item per cycle while out_stall lets results go, the
// time state updating in the last stage before the result register.
// When out_stall holds a result, the stages behind it keep filling and the
// input keeps taking items until every stage is occupied; only then does
// in_stall rise. Nothing is dropped or repeated.
// Reset (rst, synchronous) empties the pipeline, clears the seconds and the
// tick count, and places the second compare one second ahead.
module rtc_seconds_timekeeper #(
  parameter int COUNTER_BITS     = rtcst_pkg::COUNTER_BITS_DEF,
  parameter int TICKS_PER_SECOND = rtcst_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [31:0] new_seconds,
  input  logic [31:0] wait_us,
  input  logic [31:0] expiry_stamp,
  input  logic [31:0] wait_ticks_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] seconds,
  output logic [31:0] tick_count,
  output logic [31:0] millis,
  output logic [31:0] expiry_out,
  output logic [31:0] wait_ticks_out,
  output logic        expired
);

  localparam int NS         = rtcst_pkg::PIPE_STAGES;
  localparam int R_W        = $clog2(TICKS_PER_SECOND + 1);
  localparam int STEP_WHOLE = rtcst_pkg::MILLIS_PER_SECOND / TICKS_PER_SECOND;
  localparam int STEP_FRAC  = rtcst_pkg::MILLIS_PER_SECOND % TICKS_PER_SECOND;

  localparam logic [COUNTER_BITS-1:0] TPS_CNT    = COUNTER_BITS'(TICKS_PER_SECOND);
  localparam logic [COUNTER_BITS-1:0] SETTLE_CNT = COUNTER_BITS'(rtcst_pkg::SETTLE_TICKS);
  localparam logic [R_W-1:0]          SUB_LAST   = R_W'(TICKS_PER_SECOND - 1);
  localparam logic [R_W:0]            TPS_REM    = (R_W + 1)'(TICKS_PER_SECOND);
  localparam logic [R_W:0]            FRAC_STEP  = (R_W + 1)'(STEP_FRAC);
  localparam logic [9:0]              WHOLE_STEP = 10'(STEP_WHOLE);

  // pipeline occupancy and flow
  logic [NS-1:0]        occ;
  logic [NS:0]          rdy;
  rtcst_pkg::stage_en_t ld;
  rtcst_pkg::item_t     item_q [NS];
  rtcst_pkg::item_t     cur;
  logic [31:0]          wticks;
  logic                 fire;

  // time state
  logic [31:0]             secs, secs_next;
  logic [31:0]             roll, roll_next;
  logic [COUNTER_BITS-1:0] cnt, cnt_next;
  logic [COUNTER_BITS-1:0] scmp, scmp_next;
  logic [COUNTER_BITS-1:0] stcmp, stcmp_next;
  logic                    armed, armed_next;
  logic                    sec_pend, sec_pend_next;
  logic                    set_pend, set_pend_next;
  logic                    hold, hold_next;

  // extended count kept as whole seconds times 1000 plus a millisecond fraction:
  // sub_cnt * 1000 = frac * tps + frac_rem
  logic [31:0]    ms_base, ms_base_next;
  logic [R_W-1:0] sub_cnt, sub_cnt_next;
  logic [9:0]     frac, frac_next;
  logic [R_W-1:0] frac_rem, frac_rem_next;

  logic [COUNTER_BITS-1:0] cnt_inc;
  logic [R_W:0]            rem_sum;
  logic [31:0]             now;
  logic [31:0]             left;

  always_comb begin
    rdy[NS] = !out_valid || !out_stall;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !occ[k] || rdy[k+1];
    end
  end

  assign ld       = rdy[NS-1:0];
  assign in_stall = !rdy[0];
  assign cur      = item_q[NS-1];
  assign fire     = occ[NS-1] && rdy[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      if (rdy[0]) begin
        occ[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          occ[k] <= occ[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      item_q[0] <= '{kind: kind, new_seconds: new_seconds,
                     expiry_stamp: expiry_stamp, wait_ticks_in: wait_ticks_in};
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        item_q[k] <= item_q[k-1];
      end
    end
  end

  rtcst_tick_scale #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_scale (
    .clk        (clk),
    .ld         (ld),
    .wait_us    (wait_us),
    .wait_ticks (wticks)
  );

  assign cnt_inc = cnt + 1'b1;
  assign rem_sum = {1'b0, frac_rem} + FRAC_STEP;

  always_comb begin
    secs_next     = secs;
    roll_next     = roll;
    cnt_next      = cnt;
    scmp_next     = scmp;
    stcmp_next    = stcmp;
    armed_next    = armed;
    sec_pend_next = sec_pend;
    set_pend_next = set_pend;
    hold_next     = hold;
    ms_base_next  = ms_base;
    sub_cnt_next  = sub_cnt;
    frac_next     = frac;
    frac_rem_next = frac_rem;
    case (cur.kind)
      rtcst_pkg::KIND_TICK: begin
        cnt_next = cnt_inc;
        if (cnt_inc == '0) begin
          roll_next = roll + 32'd1;
        end
        if (cnt_inc == scmp) begin
          sec_pend_next = 1'b1;
        end
        if (armed && cnt_inc == stcmp) begin
          set_pend_next = 1'b1;
        end
        if (hold) begin
          if (set_pend_next) begin
            set_pend_next = 1'b0;
            sec_pend_next = 1'b0;
            armed_next    = 1'b0;
            hold_next     = 1'b0;
          end
        end else if (sec_pend_next) begin
          secs_next     = secs + 32'd1;
          sec_pend_next = 1'b0;
          scmp_next     = scmp + TPS_CNT;
        end
        // extended count wrapping to zero restarts the millisecond count
        if (cnt_inc == '0 && roll == '1) begin
          ms_base_next  = '0;
          sub_cnt_next  = '0;
          frac_next     = '0;
          frac_rem_next = '0;
        end else if (sub_cnt == SUB_LAST) begin
          ms_base_next  = ms_base + 32'(rtcst_pkg::MILLIS_PER_SECOND);
          sub_cnt_next  = '0;
          frac_next     = '0;
          frac_rem_next = '0;
        end else begin
          sub_cnt_next = sub_cnt + 1'b1;
          if (rem_sum >= TPS_REM) begin
            frac_rem_next = R_W'(rem_sum - TPS_REM);
            frac_next     = frac + WHOLE_STEP + 10'd1;
          end else begin
            frac_rem_next = R_W'(rem_sum);
            frac_next     = frac + WHOLE_STEP;
          end
        end
      end
      rtcst_pkg::KIND_SET: begin
        hold_next  = 1'b1;
        scmp_next  = cnt + TPS_CNT;
        stcmp_next = cnt + SETTLE_CNT;
        armed_next = 1'b1;
        secs_next  = cur.new_seconds;
      end
      default: begin
      end
    endcase
  end

  assign now  = 32'({roll_next, cnt_next});
  assign left = cur.expiry_stamp - now;

  always_ff @(posedge clk) begin
    if (rst) begin
      secs     <= '0;
      roll     <= '0;
      cnt      <= '0;
      scmp     <= TPS_CNT;
      stcmp    <= '0;
      armed    <= 1'b0;
      sec_pend <= 1'b0;
      set_pend <= 1'b0;
      hold     <= 1'b0;
      ms_base  <= '0;
      sub_cnt  <= '0;
      frac     <= '0;
      frac_rem <= '0;
    end else if (fire) begin
      secs     <= secs_next;
      roll     <= roll_next;
      cnt      <= cnt_next;
      scmp     <= scmp_next;
      stcmp    <= stcmp_next;
      armed    <= armed_next;
      sec_pend <= sec_pend_next;
      set_pend <= set_pend_next;
      hold     <= hold_next;
      ms_base  <= ms_base_next;
      sub_cnt  <= sub_cnt_next;
      frac     <= frac_next;
      frac_rem <= frac_rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy[NS]) begin
      out_valid <= occ[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      seconds        <= secs_next;
      tick_count     <= now;
      millis         <= ms_base_next + 32'(frac_next);
      expiry_out     <= (cur.kind == rtcst_pkg::KIND_ARM) ? now + wticks : 32'd0;
      wait_ticks_out <= (cur.kind == rtcst_pkg::KIND_ARM) ? wticks : 32'd0;
      expired        <= (cur.kind == rtcst_pkg::KIND_CHECK) && (cur.wait_ticks_in != 32'd0)
                        && (left > cur.wait_ticks_in);
    end
  end

endmodule

>>> rtl/core/rtcst_tick_scale.sv
module rtcst_tick_scale #(
  parameter int TICKS_PER_SECOND = rtcst_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                  clk,
  input  rtcst_pkg::stage_en_t  ld,
  input  logic [31:0]           wait_us,
  output logic [31:0]           wait_ticks
);

  // wait_us * tps / 1e6 = ((wait_us * tps) >> 6) / 15625
  localparam int          DIVISOR = 15625;
  localparam logic [16:0] TPS     = 17'(TICKS_PER_SECOND);
  localparam logic [29:0] RECIP_M = 30'((64'd1 << 43) / 64'd15625);

  logic [31:0] w;
  logic [48:0] p;
  logic [42:0] x2;
  logic [50:0] ph;
  logic [51:0] pl;
  logic [42:0] x3;
  logic [29:0] q3;
  logic [42:0] x4;
  logic [29:0] q4;
  logic [43:0] prod;
  logic [72:0] recip_sum;
  logic [43:0] resid;

  assign recip_sum = {ph, 22'd0} + 73'(pl);
  assign resid     = {1'b0, x4} - prod;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      w <= wait_us;
    end
    if (ld[1]) begin
      p <= 49'(w) * 49'(TPS);
    end
    // reciprocal product split in two halves of x
    if (ld[2]) begin
      x2 <= p[48:6];
      ph <= 51'(p[48:28]) * 51'(RECIP_M);
      pl <= 52'(p[27:6]) * 52'(RECIP_M);
    end
    // estimate is the quotient or one short of it
    if (ld[3]) begin
      x3 <= x2;
      q3 <= recip_sum[72:43];
    end
    if (ld[4]) begin
      x4   <= x3;
      q4   <= q3;
      prod <= 44'(q3) * 44'(DIVISOR);
    end
    if (ld[5]) begin
      wait_ticks <= 32'(q4) + ((resid >= 44'(DIVISOR)) ? 32'd1 : 32'd0);
    end
  end

endmodule

>>> test/rtc_seconds_timekeeper_tb.sv
module rtc_seconds_timekeeper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB  = rtcst_pkg::COUNTER_BITS_DEF;
  localparam int TPS = rtcst_pkg::TICKS_PER_SECOND_DEF;
  localparam longint unsigned US_PER_S = 64'd1000000;
  localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
  localparam logic [2:0] KIND_SPARE_MID = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI  = 3'd7;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] new_seconds;
    logic [31:0] wait_us;
    logic [31:0] expiry_stamp;
    logic [31:0] wait_ticks_in;
    bit          drain_first;
  } time_op_t;

  typedef struct {
    logic [31:0] seconds;
    logic [31:0] tick_count;
    logic [31:0] millis;
    logic [31:0] expiry_out;
    logic [31:0] wait_ticks_out;
    logic        expired;
  } time_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  kind = rtcst_pkg::KIND_QUERY;
  logic [31:0] new_seconds = '0;
  logic [31:0] wait_us = '0;
  logic [31:0] expiry_stamp = '0;
  logic [31:0] wait_ticks_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] seconds;
  logic [31:0] tick_count;
  logic [31:0] millis;
  logic [31:0] expiry_out;
  logic [31:0] wait_ticks_out;
  logic        expired;

  time_op_t     op_queue[$];
  time_report_t due_reports[$];

  // timekeeper state as the predictor sees it
  logic [31:0]   clk_secs;
  logic [31:0]   clk_rollovers;
  logic [CB-1:0] clk_count;
  logic [CB-1:0] clk_sec_cmp;
  logic [CB-1:0] clk_settle_cmp;
  bit            clk_settle_armed;
  bit            clk_sec_pending;
  bit            clk_settle_pending;
  bit            clk_holding;

  // generator's own view of elapsed ticks, used to aim stamps and the long run
  logic [31:0] gen_ticks;
  logic [31:0] gen_second_at;

  int  mismatches = 0;
  int  items_sent = 0;
  int  reports_seen = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  long_hold_done = 0;
  wire quiet = (items_sent % 512) >= 384;

  rtc_seconds_timekeeper u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .new_seconds    (new_seconds),
    .wait_us        (wait_us),
    .expiry_stamp   (expiry_stamp),
    .wait_ticks_in  (wait_ticks_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .seconds        (seconds),
    .tick_count     (tick_count),
    .millis         (millis),
    .expiry_out     (expiry_out),
    .wait_ticks_out (wait_ticks_out),
    .expired        (expired)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #150_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic reset_clock_model();
    clk_secs = '0;
    clk_rollovers = '0;
    clk_count = '0;
    clk_sec_cmp = CB'(TPS);
    clk_settle_cmp = '0;
    clk_settle_armed = 0;
    clk_sec_pending = 0;
    clk_settle_pending = 0;
    clk_holding = 0;
  endtask

  task automatic advance_one_tick();
    clk_count = clk_count + 1'b1;
    if (clk_count == '0) clk_rollovers = clk_rollovers + 1;
    if (clk_count == clk_sec_cmp) clk_sec_pending = 1;
    if (clk_settle_armed && clk_count == clk_settle_cmp) clk_settle_pending = 1;
    if (clk_holding) begin
      // settle match ends the hold and drops any second that came meanwhile
      if (clk_settle_pending) begin
        clk_settle_pending = 0;
        clk_sec_pending = 0;
        clk_settle_armed = 0;
        clk_holding = 0;
      end
    end else if (clk_sec_pending) begin
      clk_secs = clk_secs + 1;
      clk_sec_pending = 0;
      clk_sec_cmp = clk_sec_cmp + CB'(TPS);
    end
  endtask

  task automatic predict_time_report(input logic [2:0] k, input logic [31:0] ns,
                                     input logic [31:0] us, input logic [31:0] st,
                                     input logic [31:0] wi);
    time_report_t rep;
    logic [63:0]  ext;
    logic [63:0]  whole;
    logic [63:0]  frac;
    logic [63:0]  conv;
    logic [31:0]  now;
    logic [31:0]  left;
    if (k == rtcst_pkg::KIND_TICK) begin
      advance_one_tick();
    end else if (k == rtcst_pkg::KIND_SET) begin
      clk_holding = 1;
      clk_sec_cmp = clk_count + CB'(TPS);
      clk_settle_cmp = clk_count + CB'(rtcst_pkg::SETTLE_TICKS);
      clk_settle_armed = 1;
      clk_secs = ns;
    end
    ext = ({32'b0, clk_rollovers} << CB) | 64'(clk_count);
    now = ext[31:0];
    whole = ext / 64'(TPS);
    frac = ext % 64'(TPS);
    rep.seconds = clk_secs;
    rep.tick_count = now;
    rep.millis = 32'(whole * 64'(rtcst_pkg::MILLIS_PER_SECOND)
                     + (frac * 64'(rtcst_pkg::MILLIS_PER_SECOND)) / 64'(TPS));
    rep.expiry_out = '0;
    rep.wait_ticks_out = '0;
    rep.expired = 1'b0;
    if (k == rtcst_pkg::KIND_ARM) begin
      conv = (64'(TPS) * {32'b0, us}) / US_PER_S;
      rep.wait_ticks_out = conv[31:0];
      rep.expiry_out = now + conv[31:0];
    end else if (k == rtcst_pkg::KIND_CHECK) begin
      left = st - now;
      rep.expired = (wi != '0) && (left > wi);
    end
    due_reports.push_back(rep);
  endtask

  task automatic add_op(input logic [2:0] k, input logic [31:0] ns, input logic [31:0] us,
                        input logic [31:0] st, input logic [31:0] wi);
    time_op_t op;
    op.kind = k;
    op.new_seconds = ns;
    op.wait_us = us;
    op.expiry_stamp = st;
    op.wait_ticks_in = wi;
    // sender drains the block before these transfers
    op.drain_first = (op_queue.size() == 700) || (op_queue.size() == 1400);
    op_queue.push_back(op);
    if (k == rtcst_pkg::KIND_TICK) gen_ticks = gen_ticks + 1;
    else if (k == rtcst_pkg::KIND_SET) gen_second_at = gen_ticks + TPS;
  endtask

  task automatic add_tick();
    add_op(rtcst_pkg::KIND_TICK, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic add_random_check();
    logic [31:0] st;
    logic [31:0] wi;
    int r;
    r = $urandom_range(0, 9);
    st = (r < 7) ? gen_ticks + 32'($urandom_range(0, 40)) - 32'd20 : $urandom;
    r = $urandom_range(0, 9);
    if (r == 0) wi = '0;
    else if (r < 7) wi = $urandom_range(1, 30);
    else wi = $urandom;
    add_op(rtcst_pkg::KIND_CHECK, $urandom, $urandom, st, wi);
  endtask

  task automatic add_random_arm();
    logic [31:0] us;
    case ($urandom_range(0, 3))
      0: us = $urandom;
      1: us = $urandom_range(0, 100);
      default: us = $urandom_range(0, 5_000_000);
    endcase
    add_op(rtcst_pkg::KIND_ARM, $urandom, us, $urandom, $urandom);
  endtask

  // set time, then ticks that run out the hold unless a later set restarts it, with a few interruptions
  task automatic add_set_sequence();
    logic [31:0] ns;
    int n;
    int r;
    r = $urandom_range(0, 9);
    ns = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
    add_op(rtcst_pkg::KIND_SET, ns, $urandom, $urandom, $urandom);
    n = $urandom_range(5, 9);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) add_op(rtcst_pkg::KIND_SET, $urandom, $urandom, $urandom, $urandom);
      else if (r < 3) add_op(rtcst_pkg::KIND_QUERY, $urandom, $urandom, $urandom, $urandom);
      else if (r == 3) add_random_check();
      add_tick();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s at report %0d: expected %h, got %h",
                 name, reports_seen, want, got);
    end
  endtask

  // sender
  always @(posedge clk) begin
    time_op_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_time_report(kind, new_seconds, wait_us, expiry_stamp, wait_ticks_in);
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap == 0 && !quiet) send_gap = pick_idle();
        if (op_queue.size() != 0) nxt = op_queue[0];
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (op_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (nxt.drain_first && due_reports.size() != 0) begin
          in_valid <= 1'b0;
        end else begin
          void'(op_queue.pop_front());
          kind <= nxt.kind;
          new_seconds <= nxt.new_seconds;
          wait_us <= nxt.wait_us;
          expiry_stamp <= nxt.expiry_stamp;
          wait_ticks_in <= nxt.wait_ticks_in;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    time_report_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result transfer with nothing outstanding: seconds %h ticks %h",
                     seconds, tick_count);
        end else begin
          want = due_reports.pop_front();
          check_field("seconds", want.seconds, seconds);
          check_field("tick_count", want.tick_count, tick_count);
          check_field("millis", want.millis, millis);
          check_field("expiry_out", want.expiry_out, expiry_out);
          check_field("wait_ticks_out", want.wait_ticks_out, wait_ticks_out);
          check_field("expired", 32'(want.expired), 32'(expired));
        end
        reports_seen++;
      end
      // one long hold-off so the pipeline backs up into the input
      if (!long_hold_done && reports_seen >= 400) begin
        long_hold_done = 1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (stall_left == 0 && !quiet) stall_left = pick_idle();
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    int r;
    int n_long;
    reset_clock_model();
    gen_ticks = '0;
    gen_second_at = TPS;

    // directed: reset state, spare codes, conversion and expiry corners, hold
    add_op(rtcst_pkg::KIND_QUERY, '0, '0, '0, '0);
    add_op(KIND_SPARE_LO, '1, '1, '1, '1);
    add_op(KIND_SPARE_HI, '0, '0, '0, '0);
    add_op(KIND_SPARE_MID, $urandom, $urandom, $urandom, $urandom);
    add_tick();
    add_tick();
    add_op(rtcst_pkg::KIND_ARM, '0, 32'h0, '0, '0);
    add_op(rtcst_pkg::KIND_ARM, '1, 32'hFFFF_FFFF, '1, '1);
    add_op(rtcst_pkg::KIND_ARM, '0, 32'd1_000_000, '0, '0);
    add_op(rtcst_pkg::KIND_ARM, '0, 32'd30, '0, '0);
    add_op(rtcst_pkg::KIND_CHECK, '0, '0, 32'hFFFF_FFFF, 32'h0);
    add_op(rtcst_pkg::KIND_CHECK, '0, '0, gen_ticks, 32'd1);
    add_op(rtcst_pkg::KIND_CHECK, '0, '0, gen_ticks - 1, 32'hFFFF_FFFF);
    add_op(rtcst_pkg::KIND_CHECK, '0, '0, gen_ticks - 1, 32'd1);
    add_op(rtcst_pkg::KIND_CHECK, '0, '0, 32'h0, 32'hFFFF_FFFF);
    add_op(rtcst_pkg::KIND_SET, 32'hFFFF_FFFF, '0, '0, '0);
    add_tick();
    add_tick();
    add_op(rtcst_pkg::KIND_SET, 32'h0, '0, '0, '0);
    for (int i = 0; i < 6; i++) add_tick();
    add_op(rtcst_pkg::KIND_QUERY, '1, '1, '1, '1);

    while (op_queue.size() < 1900) begin
      r = $urandom_range(0, 99);
      if (r < 8) add_set_sequence();
      else if (r < 50) add_tick();
      else if (r < 58) add_op(rtcst_pkg::KIND_QUERY, $urandom, $urandom, $urandom, $urandom);
      else if (r < 70) add_random_arm();
      else if (r < 92) add_random_check();
      else add_op(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
                  $urandom, $urandom, $urandom, $urandom);
    end

    // run the counter past the next second compare so the seconds step
    n_long = int'(gen_second_at - gen_ticks) + 40;
    while (n_long > 0) begin
      r = $urandom_range(0, 299);
      if (r == 0) add_op(rtcst_pkg::KIND_QUERY, $urandom, $urandom, $urandom, $urandom);
      else if (r == 1) add_random_check();
      else begin
        add_tick();
        n_long--;
      end
    end
    add_random_arm();
    add_set_sequence();
    add_op(rtcst_pkg::KIND_QUERY, $urandom, $urandom, $urandom, $urandom);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (op_queue.size() != 0 || in_valid || due_reports.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

>>> rtc_seconds_timekeeper.f
rtl/core/rtcst_pkg.sv
rtl/core/rtcst_tick_scale.sv
rtl/core/rtc_seconds_timekeeper.sv
test/rtc_seconds_timekeeper_tb.sv
